>>> hw/rtl/dasn_pkg.sv
// Shared types and constants for the decimal text to scaled number core.
package dasn_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FRAC_W     = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic REG_ALLOW_FRACTION = 1'b0;

    typedef enum logic [3:0] {
        P_START = 4'b0001,
        P_INT   = 4'b0010,
        P_FRAC  = 4'b0100,
        P_DONE  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    typedef struct packed {
        logic              neg;
        logic [FRAC_W-1:0] frac;
        t_status           status;
    } t_res_ctl;

endpackage

>>> hw/rtl/dasn_char_if.sv
// Character request channel: one ASCII character and an end-of-text mark.
interface dasn_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

>>> hw/rtl/dasn_num_if.sv
// Number request channel: signed mantissa, fraction digit count and status.
interface dasn_num_if #(
    parameter int MANTISSA_BITS = 48
);
    logic                                 valid;
    logic                                 ready;
    logic signed [MANTISSA_BITS:0]        mantissa;
    logic [dasn_pkg::FRAC_W-1:0]          frac_digits;
    dasn_pkg::t_status                    status;

    modport source (output valid, output mantissa, output frac_digits, output status,
                     input ready);
    modport sink   (input valid, input mantissa, input frac_digits, input status,
                     output ready);
endinterface

>>> hw/rtl/dasn_parse.sv
// Parse stage: per-character state update and capture of the finished number.
module dasn_parse #(
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_allow_frac,
    dasn_char_if.sink                  i_char,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [MANTISSA_BITS-1:0]   o_res_mag,
    output dasn_pkg::t_res_ctl         o_res_ctl
);
    import dasn_pkg::*;

    localparam int PW = MANTISSA_BITS + 4;
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_FRAC_DIGITS);

    t_phase                   r_phase, n_phase;
    logic                     r_neg, n_neg;
    logic [MANTISSA_BITS-1:0] r_accum, n_accum;
    logic [FRAC_W-1:0]        r_frac, n_frac;
    t_status                  r_err, n_err;

    logic                     r_res_valid;
    logic [MANTISSA_BITS-1:0] r_res_mag;
    t_res_ctl                 r_res_ctl;

    logic [7:0]  c;
    logic        accept;
    t_phase      eff_phase;
    logic        is_sign;
    logic        is_digit;
    logic [PW-1:0] prod;
    logic        fits;

    assign c        = i_char.char_code;
    assign i_char.ready = !r_res_valid || i_res_ready;
    assign accept   = i_char.valid && i_char.ready;

    assign eff_phase = (r_phase == P_START) ? P_INT : r_phase;
    assign is_sign   = (r_phase == P_START) && (c == CHAR_PLUS || c == CHAR_MINUS);
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign prod      = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) + PW'(c[3:0]);
    assign fits      = (prod[PW-1:MANTISSA_BITS] == 4'b0);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_accum = r_accum;
        n_frac  = r_frac;
        n_err   = r_err;
        if (r_phase != P_DONE) begin
            if (c == CHAR_NUL) begin
                if (r_phase == P_START) begin
                    n_err = ST_EMPTY;
                end
                n_phase = P_DONE;
            end else begin
                n_phase = eff_phase;
                if (is_sign) begin
                    if (c == CHAR_MINUS) begin
                        n_neg = 1'b1;
                    end
                end else if (is_digit) begin
                    if (eff_phase == P_INT) begin
                        if (fits) begin
                            n_accum = prod[MANTISSA_BITS-1:0];
                        end else begin
                            n_accum = '1;
                            n_err   = ST_OVF;
                        end
                    end else if (r_frac < FRAC_MAX && fits) begin
                        n_accum = prod[MANTISSA_BITS-1:0];
                        n_frac  = r_frac + 4'd1;
                    end
                end else if (c == CHAR_POINT && i_allow_frac) begin
                    n_phase = (eff_phase == P_INT) ? P_FRAC : P_DONE;
                end else begin
                    n_err   = ST_BAD;
                    n_phase = P_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_START;
            r_neg       <= 1'b0;
            r_accum     <= '0;
            r_frac      <= '0;
            r_err       <= ST_OK;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (accept) begin
                if (i_char.is_last) begin
                    r_res_valid      <= 1'b1;
                    r_res_mag        <= n_accum;
                    r_res_ctl.neg    <= n_neg;
                    r_res_ctl.frac   <= n_frac;
                    r_res_ctl.status <= n_err;
                    r_phase          <= P_START;
                    r_neg            <= 1'b0;
                    r_accum          <= '0;
                    r_frac           <= '0;
                    r_err            <= ST_OK;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_accum <= n_accum;
                    r_frac  <= n_frac;
                    r_err   <= n_err;
                end
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_mag   = r_res_mag;
    assign o_res_ctl   = r_res_ctl;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_char.is_last |=> r_phase == P_START && r_accum == '0 && !r_neg)
        else $error("parse state not cleared after last character");
    a_frac_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= FRAC_MAX)
        else $error("fraction count above cap");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> r_res_valid && $stable(r_res_ctl)
        && $stable(r_res_mag))
        else $error("parse result changed while stalled");
`endif

endmodule

>>> hw/rtl/dasn_format.sv
// Output stage: sign application, error zeroing and skid-buffered result register.
module dasn_format #(
    parameter int MANTISSA_BITS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_res_valid,
    output logic                       o_res_ready,
    input  logic [MANTISSA_BITS-1:0]   i_res_mag,
    input  dasn_pkg::t_res_ctl         i_res_ctl,
    dasn_num_if.source                 o_num
);
    import dasn_pkg::*;

    localparam int OW = MANTISSA_BITS + 1;

    logic                 zero_res;
    logic [OW-1:0]        mag_ext;
    logic [OW-1:0]        n_mant;
    logic [FRAC_W-1:0]    n_frac;

    logic                 r_out_valid;
    logic [OW-1:0]        r_out_mant;
    logic [FRAC_W-1:0]    r_out_frac;
    t_status              r_out_status;

    logic                 r_skid_valid;
    logic [OW-1:0]        r_skid_mant;
    logic [FRAC_W-1:0]    r_skid_frac;
    t_status              r_skid_status;

    logic                 take_in;
    logic                 take_out;

    assign zero_res = (i_res_ctl.status == ST_EMPTY) || (i_res_ctl.status == ST_BAD);
    assign mag_ext  = {1'b0, i_res_mag};
    assign n_mant   = zero_res ? '0 : (i_res_ctl.neg ? (~mag_ext + 1'b1) : mag_ext);
    assign n_frac   = zero_res ? '0 : i_res_ctl.frac;

    assign o_res_ready = !r_skid_valid;
    assign take_in     = i_res_valid && !r_skid_valid;
    assign take_out    = r_out_valid && o_num.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_mant   <= r_skid_mant;
                r_out_frac   <= r_skid_frac;
                r_out_status <= r_skid_status;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= take_in;
                r_out_mant   <= n_mant;
                r_out_frac   <= n_frac;
                r_out_status <= i_res_ctl.status;
            end
        end else if (take_in) begin
            r_skid_valid  <= 1'b1;
            r_skid_mant   <= n_mant;
            r_skid_frac   <= n_frac;
            r_skid_status <= i_res_ctl.status;
        end
    end

    assign o_num.valid       = r_out_valid;
    assign o_num.mantissa    = r_out_mant;
    assign o_num.frac_digits = r_out_frac;
    assign o_num.status      = r_out_status;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_EMPTY || r_out_status == ST_BAD)
        |-> r_out_mant == '0 && r_out_frac == '0)
        else $error("error result carries nonzero fields");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && take_out |=> !r_skid_valid && r_out_valid)
        else $error("skid entry not moved to output");
`endif

endmodule

>>> hw/rtl/decimal_ascii_to_scaled_number_core.sv
// Top level: configuration register, parse stage and output stage.
//
// Accepts one ASCII character per clock while the character channel is ready
// (the parse stage stalls while its result is held) and gives one result per
// text on the character marked last. The parse stage applies the times-ten-
// plus-digit update combinationally, so the sustained rate is one character
// per cycle when not stalled. A result loads the parse result register when
// its last character is taken and then passes to the output register. The
// output register has a skid entry behind it, so input continues while a
// result waits; with the output stalled, input stops once three results are
// held. Register allow_fraction (byte address 0, reset 1) selects decimal or
// integer parsing; write only while no text is in flight (not enforced).
module decimal_ascii_to_scaled_number_core #(
    parameter int MANTISSA_BITS   = 48,
    parameter int MAX_FRAC_DIGITS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dasn_char_if.sink                           i_char,
    dasn_num_if.source                          o_num,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dasn_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dasn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dasn_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dasn_pkg::*;

    logic                     r_allow_frac;
    logic                     res_valid;
    logic                     res_ready;
    logic [MANTISSA_BITS-1:0] res_mag;
    t_res_ctl                 res_ctl;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_ALLOW_FRACTION);
    assign prdata  = reg_sel ? {{(APB_DATA_W-1){1'b0}}, r_allow_frac} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_frac <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_allow_frac <= pwdata[0];
        end
    end

    dasn_parse #(
        .MANTISSA_BITS   (MANTISSA_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_allow_frac (r_allow_frac),
        .i_char       (i_char),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_mag    (res_mag),
        .o_res_ctl    (res_ctl)
    );

    dasn_format #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_format (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res_mag   (res_mag),
        .i_res_ctl   (res_ctl),
        .o_num       (o_num)
    );

endmodule
